### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### sv/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg
// Types and constants shared by the glyph leg counter modules.
// ----------------------------------------------------------------------------
package glc_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_LEGS_DEF    = 32;

    localparam logic [8:0] WIDTH_RST  = 9'd8;
    localparam logic [7:0] HEIGHT_RST = 8'd8;
    localparam logic [5:0] STRIDE_RST = 6'd1;
    localparam logic [1:0] MODE_RST   = 2'd0;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_STRIDE = 2'd2,
        CFG_MODE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_WEAK   = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_STRONG = 2'd2
    } filter_mode_t;

    typedef enum logic [2:0] {
        F_LOAD,
        F_WRITE,
        F_P1_RD,
        F_P1_WR,
        F_WAIT,
        F_P2_FETCH,
        F_P2_BIT,
        F_P2_END
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [7:0] leg_count;
        logic [8:0] first_leg_end;
        logic [8:0] second_leg_start;
        logic       none;
    } summary_t;

    typedef struct packed {
        logic [7:0] leg_count;
        logic       leg_valid;
        logic [4:0] leg_index;
        logic [8:0] leg_center;
        logic [8:0] leg_width;
        logic [8:0] first_leg_end;
        logic [8:0] second_leg_start;
        logic       last_result;
    } item_t;

endpackage

### sv/glc_ram.sv
// ----------------------------------------------------------------------------
// glc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/glc_front.sv
// ----------------------------------------------------------------------------
// glc_front
// Accepts raster bytes, accumulates column counts, then marks, filters and
// segments the columns into legs for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glc_front #(
    parameter int MAX_COLUMNS = glc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LEGS    = glc_pkg::MAX_LEGS_DEF,
    localparam int CW  = $clog2(MAX_COLUMNS + 1),
    localparam int ROWS = (MAX_COLUMNS + 7) / 8,
    localparam int RA  = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int NRW = $clog2(ROWS + 1),
    localparam int LW  = $clog2(MAX_LEGS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          pixel_byte,
    input  logic [8:0]          cfg_width,
    input  logic [7:0]          cfg_height,
    input  logic [5:0]          cfg_stride,
    input  logic [1:0]          cfg_mode,
    output logic                leg_we,
    output logic [LW-1:0]       leg_waddr,
    output logic [2*CW-1:0]     leg_wdata,
    output logic                sum_valid,
    output glc_pkg::summary_t   summary,
    output logic [LW-1:0]       last_k,
    input  logic                sum_done
);

    glc_pkg::front_state_t state_reg, state_next;

    logic [4:0]      bp_reg;
    logic [7:0]      rp_reg;
    logic [ROWS-1:0] row_valid_reg;
    logic            sum_valid_reg;

    logic [7:0]      px_reg;
    logic [RA-1:0]   crow_reg;
    logic            add_reg, end_reg, vld_reg;
    logic [NRW-1:0]  r_reg;
    logic            prev_reg;
    logic [1:0]      rises_reg;
    logic            strong_reg;
    logic [CW-1:0]   j_reg;
    logic [7:0]      rowbuf_reg;
    logic            m1_reg, m2_reg, sp_reg;
    logic [CW-1:0]   start_reg, legs_reg, fe_reg, ss_reg;
    glc_pkg::summary_t sum_reg;
    logic [LW-1:0]   last_k_reg;

    logic [CW-1:0]   w_eff;
    logic [CW:0]     wp7;
    logic [NRW-1:0]  nrows;
    logic [7:0]      h_eff, thr;
    logic [5:0]      stride_eff;
    logic            accept, bp_inc, row_inc, p1_last;

    logic [RA-1:0]   c_raddr;
    logic            c_we;
    logic [63:0]     c_wdata, c_rdata;
    logic            r_we;
    logic [7:0]      r_wdata, r_rdata;
    logic [1:0]      rs_next;
    logic            pv_next;

    logic            j_lt_w, nbit, interior, filt, col_ok, rec, start_set, strong_now;
    logic [CW-1:0]   rec_end, j_next, legs_total, fe_fin, ss_fin;
    int              n_items;

    assign w_eff = (32'(cfg_width) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cfg_width);
    assign wp7   = {1'b0, w_eff} + (CW + 1)'(7);
    assign nrows = NRW'(wp7 >> 3);
    assign h_eff = (cfg_height == 8'd0) ? 8'd1 : cfg_height;
    assign thr   = h_eff - (h_eff >> 3);
    assign stride_eff = (cfg_stride == 6'd0) ? 6'd1 :
                        ((cfg_stride > 6'd32) ? 6'd32 : cfg_stride);

    assign full    = (state_reg != glc_pkg::F_LOAD);
    assign accept  = push && !full;
    assign bp_inc  = (32'(bp_reg) + 1) < 32'(stride_eff);
    assign row_inc = (32'(rp_reg) + 1) < 32'(h_eff);
    assign p1_last = (32'(r_reg) + 1) == 32'(nrows);

    assign c_raddr = (state_reg == glc_pkg::F_LOAD) ? RA'(bp_reg) : RA'(r_reg);
    assign c_we    = (state_reg == glc_pkg::F_WRITE) && add_reg;
    assign r_we    = (state_reg == glc_pkg::F_P1_WR);

    always_comb
    begin
        logic [7:0] old_cnt, cnt;
        logic       inc, raw_b;
        int         col;
        c_wdata = '0;
        r_wdata = '0;
        rs_next = rises_reg;
        pv_next = prev_reg;
        for (int b = 0; b < 8; b++)
        begin
            old_cnt = vld_reg ? c_rdata[8*b +: 8] : 8'd0;
            col = 32'(crow_reg) * 8 + b;
            inc = px_reg[7-b] && (col < MAX_COLUMNS);
            c_wdata[8*b +: 8] = old_cnt + 8'(inc);

            cnt = vld_reg ? c_rdata[8*b +: 8] : 8'd0;
            col = 32'(r_reg) * 8 + b;
            raw_b = (cnt >= thr) && (col < 32'(w_eff));
            if (!pv_next && raw_b && (rs_next != 2'd3))
            begin
                rs_next = rs_next + 2'd1;
            end
            pv_next = raw_b;
            r_wdata[7-b] = raw_b;
        end
    end

    assign j_lt_w   = j_reg < w_eff;
    assign nbit     = j_lt_w ? ((j_reg[2:0] == 3'd0) ? r_rdata[7] : rowbuf_reg[~j_reg[2:0]])
                             : 1'b0;
    assign interior = (j_reg >= CW'(2)) && j_lt_w;
    assign col_ok   = (j_reg != '0);
    assign j_next   = j_reg + CW'(1);

    always_comb
    begin
        filt = m1_reg;
        if (interior)
        begin
            if (m2_reg && !m1_reg && nbit)
            begin
                filt = 1'b1;
            end
            if (strong_reg && !m2_reg && m1_reg && !nbit)
            begin
                filt = 1'b0;
            end
        end
    end

    assign strong_now = !((cfg_mode == glc_pkg::MODE_WEAK) ||
                          ((rises_reg <= 2'd2) && (cfg_mode != glc_pkg::MODE_STRONG)));

    always_comb
    begin
        rec = 1'b0;
        start_set = 1'b0;
        rec_end = j_reg - CW'(1);
        if (state_reg == glc_pkg::F_P2_BIT)
        begin
            rec = col_ok && !filt && sp_reg;
            start_set = col_ok && filt && !sp_reg;
        end
        else if (state_reg == glc_pkg::F_P2_END)
        begin
            rec = sp_reg;
            rec_end = w_eff;
        end
    end

    assign leg_we     = rec && (32'(legs_reg) < MAX_LEGS);
    assign leg_waddr  = LW'(legs_reg);
    assign leg_wdata  = {start_reg, rec_end};
    assign legs_total = legs_reg + CW'(rec);
    assign fe_fin     = (rec && legs_reg == '0) ? rec_end : fe_reg;
    assign ss_fin     = (rec && legs_reg == CW'(1)) ? (start_reg - CW'(1)) : ss_reg;
    assign n_items    = (32'(legs_total) < MAX_LEGS) ? 32'(legs_total) : MAX_LEGS;

    glc_ram #(.WIDTH(64), .DEPTH(ROWS)) u_count_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (crow_reg),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    glc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_raw_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (RA'(r_reg)),
        .wdata (r_wdata),
        .raddr (RA'(j_reg >> 3)),
        .rdata (r_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glc_pkg::F_LOAD:
            begin
                if (accept)
                begin
                    state_next = glc_pkg::F_WRITE;
                end
            end
            glc_pkg::F_WRITE:
            begin
                if (!end_reg)
                begin
                    state_next = glc_pkg::F_LOAD;
                end
                else if (nrows == '0)
                begin
                    state_next = glc_pkg::F_WAIT;
                end
                else
                begin
                    state_next = glc_pkg::F_P1_RD;
                end
            end
            glc_pkg::F_P1_RD: state_next = glc_pkg::F_P1_WR;
            glc_pkg::F_P1_WR:
            begin
                state_next = p1_last ? glc_pkg::F_WAIT : glc_pkg::F_P1_RD;
            end
            glc_pkg::F_WAIT:
            begin
                if (!sum_valid_reg)
                begin
                    state_next = (w_eff == '0) ? glc_pkg::F_P2_BIT : glc_pkg::F_P2_FETCH;
                end
            end
            glc_pkg::F_P2_FETCH: state_next = glc_pkg::F_P2_BIT;
            glc_pkg::F_P2_BIT:
            begin
                if (j_reg == w_eff)
                begin
                    state_next = glc_pkg::F_P2_END;
                end
                else if (j_next[2:0] == 3'd0 && j_next < w_eff)
                begin
                    state_next = glc_pkg::F_P2_FETCH;
                end
            end
            glc_pkg::F_P2_END: state_next = glc_pkg::F_LOAD;
            default: state_next = glc_pkg::F_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= glc_pkg::F_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg        <= '0;
            rp_reg        <= '0;
            row_valid_reg <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (bp_inc)
                begin
                    bp_reg <= bp_reg + 5'd1;
                end
                else
                begin
                    bp_reg <= '0;
                    rp_reg <= row_inc ? (rp_reg + 8'd1) : 8'd0;
                end
            end
            if (c_we)
            begin
                row_valid_reg[crow_reg] <= 1'b1;
            end
            if ((state_reg == glc_pkg::F_P1_WR && p1_last) ||
                (state_reg == glc_pkg::F_WRITE && end_reg && nrows == '0))
            begin
                row_valid_reg <= '0;
            end
            if (state_reg == glc_pkg::F_P2_END)
            begin
                sum_valid_reg <= 1'b1;
            end
            else if (sum_done)
            begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            glc_pkg::F_LOAD:
            begin
                if (accept)
                begin
                    px_reg   <= pixel_byte;
                    crow_reg <= RA'(bp_reg);
                    add_reg  <= 32'(bp_reg) < 32'(nrows);
                    end_reg  <= !bp_inc && !row_inc;
                    vld_reg  <= row_valid_reg[RA'(bp_reg)];
                end
            end
            glc_pkg::F_WRITE:
            begin
                r_reg     <= '0;
                rises_reg <= '0;
                prev_reg  <= 1'b0;
            end
            glc_pkg::F_P1_RD:
            begin
                vld_reg <= row_valid_reg[RA'(r_reg)];
            end
            glc_pkg::F_P1_WR:
            begin
                r_reg     <= r_reg + NRW'(1);
                rises_reg <= rs_next;
                prev_reg  <= pv_next;
            end
            glc_pkg::F_WAIT:
            begin
                strong_reg <= strong_now;
                j_reg      <= '0;
                legs_reg   <= '0;
                sp_reg     <= 1'b0;
                m1_reg     <= 1'b0;
                m2_reg     <= 1'b0;
                fe_reg     <= '0;
                ss_reg     <= '0;
            end
            glc_pkg::F_P2_BIT:
            begin
                if (j_reg[2:0] == 3'd0)
                begin
                    rowbuf_reg <= r_rdata;
                end
                if (start_set)
                begin
                    start_reg <= j_reg - CW'(1);
                end
                if (rec)
                begin
                    legs_reg <= legs_total;
                    fe_reg   <= fe_fin;
                    ss_reg   <= ss_fin;
                end
                m2_reg <= m1_reg;
                m1_reg <= nbit;
                if (col_ok)
                begin
                    sp_reg <= filt;
                end
                j_reg <= j_next;
            end
            glc_pkg::F_P2_END:
            begin
                sum_reg.leg_count        <= 8'(legs_total);
                sum_reg.none             <= (legs_total == '0);
                sum_reg.first_leg_end    <= (legs_total == CW'(2)) ? 9'(fe_fin) : 9'd0;
                sum_reg.second_leg_start <= (legs_total == CW'(2)) ? 9'(ss_fin) : 9'd0;
                last_k_reg               <= LW'(n_items - 1);
            end
            default:
            begin
            end
        endcase
    end

    assign sum_valid = sum_valid_reg;
    assign summary   = sum_reg;
    assign last_k    = last_k_reg;

    `ASSERT_NEVER(a_leg_write_busy, clk, rst_n, leg_we && sum_valid_reg,
        "leg store written while the back end still owns it")
    `ASSERT_ON(a_done_when_held, clk, rst_n, sum_done |-> sum_valid_reg,
        "summary released while none is held")

endmodule

### sv/glc_back.sv
// ----------------------------------------------------------------------------
// glc_back
// Reads the stored legs of a finished glyph and queues one result beat per
// stored leg, or a single beat when there are none, in a two-entry output queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glc_back #(
    parameter int MAX_COLUMNS = glc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LEGS    = glc_pkg::MAX_LEGS_DEF,
    localparam int CW = $clog2(MAX_COLUMNS + 1),
    localparam int LW = $clog2(MAX_LEGS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sum_valid,
    input  glc_pkg::summary_t   summary,
    input  logic [LW-1:0]       last_k,
    output logic                sum_done,
    output logic [LW-1:0]       leg_raddr,
    input  logic [2*CW-1:0]     leg_rdata,
    output logic                empty,
    input  logic                pop,
    output glc_pkg::item_t      item
);

    glc_pkg::back_state_t st_reg, st_next;
    logic [LW-1:0]  k_reg;
    logic [1:0]     cnt_reg;
    logic           wp_reg, rp_reg;
    glc_pkg::item_t q_reg [2];

    logic           push_en, pop_en, last_item;
    logic [CW-1:0]  l_start, l_end;
    logic [CW:0]    l_sum;
    glc_pkg::item_t new_item;

    assign l_start   = leg_rdata[2*CW-1:CW];
    assign l_end     = leg_rdata[CW-1:0];
    assign l_sum     = {1'b0, l_start} + {1'b0, l_end};
    assign last_item = summary.none || (k_reg == last_k);
    assign push_en   = (st_reg == glc_pkg::B_EMIT) && (cnt_reg != 2'd2);
    assign pop_en    = pop && (cnt_reg != 2'd0);
    assign sum_done  = push_en && last_item;
    assign leg_raddr = k_reg;

    always_comb
    begin
        new_item.leg_count        = summary.leg_count;
        new_item.leg_valid        = !summary.none;
        new_item.leg_index        = summary.none ? 5'd0 : 5'(k_reg);
        new_item.leg_center       = summary.none ? 9'd0 : 9'(l_sum >> 1);
        new_item.leg_width        = summary.none ? 9'd0 : 9'(l_end - l_start);
        new_item.first_leg_end    = summary.first_leg_end;
        new_item.second_leg_start = summary.second_leg_start;
        new_item.last_result      = last_item;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            glc_pkg::B_IDLE:
            begin
                if (sum_valid)
                begin
                    st_next = glc_pkg::B_READ;
                end
            end
            glc_pkg::B_READ: st_next = glc_pkg::B_EMIT;
            glc_pkg::B_EMIT:
            begin
                if (push_en)
                begin
                    st_next = last_item ? glc_pkg::B_IDLE : glc_pkg::B_READ;
                end
            end
            default: st_next = glc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= glc_pkg::B_IDLE;
            k_reg   <= '0;
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == glc_pkg::B_IDLE)
            begin
                k_reg <= '0;
            end
            else if (push_en)
            begin
                k_reg <= k_reg + LW'(1);
            end
            if (push_en)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop_en)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push_en) - 2'(pop_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_reg[wp_reg] <= new_item;
        end
    end

    assign empty = (cnt_reg == 2'd0);
    assign item  = q_reg[rp_reg];

    `ASSERT_ON(a_busy_needs_summary, clk, rst_n, (st_reg != glc_pkg::B_IDLE) |-> sum_valid,
        "back end running without a held summary")

endmodule

### sv/glyph_leg_counter.sv
// ----------------------------------------------------------------------------
// glyph_leg_counter
// Counts the vertical strokes of a 1-bit glyph raster and lists them.
//
// Input queue: push/full with pixel_byte, one raster byte per beat, row by
// row, row_stride_bytes bytes per row. Each byte is a count memory read,
// then a write, and full is high during the write, so no byte is taken in it.
// After the last byte of a glyph the front end runs a mark pass over the
// ceil(w/8) rows of the count memory, then a column pass, one column per
// cycle apart from a row fetch before each group of eight, w = glyph width.
// Result queue: empty/pop; the back end emits one beat per stored leg (leg
// store read, then enqueue) into a two-entry output queue. The front end
// loads the next glyph while results drain; its column pass waits until the
// back end has released the leg store.
// A stalled receiver fills the output queue and holds the back end; bytes
// are still taken until the next glyph needs its column pass.
// Reset returns the registers to width 8, height 8, stride 1, weak filter,
// empties both queues and marks every count row invalid, so no clearing
// pass is needed. Configuration writes take effect at the next cycle.
// ----------------------------------------------------------------------------
module glyph_leg_counter #(
    parameter int MAX_COLUMNS = glc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LEGS    = glc_pkg::MAX_LEGS_DEF,
    localparam int CW = $clog2(MAX_COLUMNS + 1),
    localparam int LW = $clog2(MAX_LEGS)
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] pixel_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] leg_count,
    output logic       leg_valid,
    output logic [4:0] leg_index,
    output logic [8:0] leg_center,
    output logic [8:0] leg_width,
    output logic [8:0] first_leg_end,
    output logic [8:0] second_leg_start,
    output logic       last_result
);

    logic [8:0] width_reg;
    logic [7:0] height_reg;
    logic [5:0] stride_reg;
    logic [1:0] mode_reg;

    logic              leg_we, sum_valid, sum_done;
    logic [LW-1:0]     leg_waddr, leg_raddr, last_k;
    logic [2*CW-1:0]   leg_wdata, leg_rdata;
    glc_pkg::summary_t summary;
    glc_pkg::item_t    item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= glc_pkg::WIDTH_RST;
            height_reg <= glc_pkg::HEIGHT_RST;
            stride_reg <= glc_pkg::STRIDE_RST;
            mode_reg   <= glc_pkg::MODE_RST;
        end
        else if (cfg_write)
        begin
            case (glc_pkg::cfg_index_t'(cfg_index))
                glc_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                glc_pkg::CFG_HEIGHT: height_reg <= cfg_data[7:0];
                glc_pkg::CFG_STRIDE: stride_reg <= cfg_data[5:0];
                glc_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    glc_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_LEGS(MAX_LEGS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_byte (pixel_byte),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cfg_stride (stride_reg),
        .cfg_mode   (mode_reg),
        .leg_we     (leg_we),
        .leg_waddr  (leg_waddr),
        .leg_wdata  (leg_wdata),
        .sum_valid  (sum_valid),
        .summary    (summary),
        .last_k     (last_k),
        .sum_done   (sum_done)
    );

    glc_ram #(.WIDTH(2 * CW), .DEPTH(MAX_LEGS)) u_leg_ram (
        .clk   (clk),
        .we    (leg_we),
        .waddr (leg_waddr),
        .wdata (leg_wdata),
        .raddr (leg_raddr),
        .rdata (leg_rdata)
    );

    glc_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_LEGS(MAX_LEGS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .summary   (summary),
        .last_k    (last_k),
        .sum_done  (sum_done),
        .leg_raddr (leg_raddr),
        .leg_rdata (leg_rdata),
        .empty     (empty),
        .pop       (pop),
        .item      (item)
    );

    assign leg_count        = item.leg_count;
    assign leg_valid        = item.leg_valid;
    assign leg_index        = item.leg_index;
    assign leg_center       = item.leg_center;
    assign leg_width        = item.leg_width;
    assign first_leg_end    = item.first_leg_end;
    assign second_leg_start = item.second_leg_start;
    assign last_result      = item.last_result;

endmodule
